// File: sv/jdfb_pkg.sv
// shared types, constants and functions of the joystick drive frame builder
package jdfb_pkg;

    localparam int IN_LIMIT     = 390;
    localparam int SPEED_LIMIT  = 250;
    localparam int ZERO_REPEATS = 3;

    localparam int RAW_W  = 10;
    localparam int BAND_W = 9;
    localparam int DIFF_W = RAW_W + 1;
    localparam int MIX_W  = DIFF_W + 1;
    localparam int WORD_W = 16;
    localparam int OUT_W  = 9;

    localparam logic [WORD_W-1:0] START_MARK = 16'hACBD;
    localparam logic [WORD_W-1:0] CMD_NONE   = 16'h0000;
    localparam logic [WORD_W-1:0] CMD_ON     = 16'h0101;
    localparam logic [WORD_W-1:0] CMD_OFF    = 16'h0202;

    // register indexes on the apb port
    localparam logic [1:0] REG_X_CENTER    = 2'd0;
    localparam logic [1:0] REG_Y_CENTER    = 2'd1;
    localparam logic [1:0] REG_CENTER_BAND = 2'd2;
    localparam logic [1:0] REG_DEAD_ZONE   = 2'd3;

    localparam logic [RAW_W-1:0]  X_CENTER_RST    = 10'd508;
    localparam logic [RAW_W-1:0]  Y_CENTER_RST    = 10'd558;
    localparam logic [BAND_W-1:0] CENTER_BAND_RST = 9'd20;
    localparam logic [BAND_W-1:0] DEAD_ZONE_RST   = 9'd70;

    typedef enum logic [1:0] {
        FUNC_SAMPLE     = 2'd0,
        FUNC_BLADE_RUN  = 2'd1,
        FUNC_BLADE_STOP = 2'd2,
        FUNC_UNUSED     = 2'd3
    } func_t;

    // blade code uses the same encoding as the button func codes
    localparam logic [1:0] BLADE_NONE = 2'd0;
    localparam logic [1:0] BLADE_RUN  = 2'd1;
    localparam logic [1:0] BLADE_STOP = 2'd2;

    // scaling (u * 2*SPEED_LIMIT) / (2*IN_LIMIT) done as u * K >> SHIFT, exact over u range
    localparam longint DIV      = 2 * IN_LIMIT;
    localparam longint NUM_MAX  = DIV * 2 * SPEED_LIMIT;
    localparam int     SHIFT    = $clog2(NUM_MAX * DIV + 1);
    localparam longint RECIP    = ((64'sd1 <<< SHIFT) + DIV - 1) / DIV;
    localparam longint SCALE_K  = RECIP * 2 * SPEED_LIMIT;
    localparam int     K_W      = $clog2(SCALE_K + 1);
    localparam int     U_W      = $clog2(2 * IN_LIMIT + 1);
    localparam int     PROD_W   = U_W + K_W;
    localparam int     Q_W      = $clog2(2 * SPEED_LIMIT + 1);
    localparam int     SPD_W    = $clog2(SPEED_LIMIT + 1) + 1;
    localparam int     ZC_W     = (ZERO_REPEATS > 0) ? $clog2(ZERO_REPEATS + 1) : 1;

    function automatic logic [WORD_W-1:0] cmd_of(input logic [1:0] code);
        logic [WORD_W-1:0] c;
        case (code)
            BLADE_RUN:  c = CMD_ON;
            BLADE_STOP: c = CMD_OFF;
            default:    c = CMD_NONE;
        endcase
        return c;
    endfunction

endpackage

// File: sv/jdfb_shape.sv
// clamp, dead zone and linear scaling of one mixed drive value
module jdfb_shape (
    input  logic signed [jdfb_pkg::MIX_W-1:0]  mix,
    input  logic        [jdfb_pkg::BAND_W-1:0] dead_zone,
    output logic signed [jdfb_pkg::SPD_W-1:0]  speed
);

    localparam logic signed [jdfb_pkg::MIX_W-1:0] LIM = jdfb_pkg::MIX_W'(jdfb_pkg::IN_LIMIT);

    logic signed [jdfb_pkg::MIX_W-1:0] mag;
    logic signed [jdfb_pkg::MIX_W-1:0] shaped;
    logic signed [jdfb_pkg::MIX_W-1:0] offset;
    logic        [jdfb_pkg::U_W-1:0]    u;
    logic        [jdfb_pkg::PROD_W-1:0] prod;
    logic        [jdfb_pkg::Q_W-1:0]    q;
    logic signed [jdfb_pkg::Q_W:0]      centered;

    always_comb
    begin
        mag = (mix < 0) ? -mix : mix;
        if (mix > LIM)
        begin
            shaped = LIM;
        end
        else if (mix < -LIM)
        begin
            shaped = -LIM;
        end
        else if ((mag != '0) && (mag < $signed({3'b000, dead_zone})))
        begin
            shaped = '0;
        end
        else
        begin
            shaped = mix;
        end
        // offset into 0 .. 2*IN_LIMIT, never negative
        offset   = shaped + LIM;
        u        = offset[jdfb_pkg::U_W-1:0];
        prod     = jdfb_pkg::PROD_W'(u) * jdfb_pkg::PROD_W'(jdfb_pkg::SCALE_K);
        q        = prod[jdfb_pkg::SHIFT +: jdfb_pkg::Q_W];
        centered = $signed({1'b0, q}) - (jdfb_pkg::Q_W + 1)'(jdfb_pkg::SPEED_LIMIT);
        speed    = jdfb_pkg::SPD_W'(centered);
    end

endmodule

// File: sv/joystick_drive_frame_builder_core.sv
// joystick drive frame builder: top level with apb registers and frame pipeline
//
// input channel (in_valid/in_ready) carries one item: func selects a joystick
// sample (x_sample, y_sample) or a blade on / blade off button press.
// output channel (out_valid/out_ready) carries one frame: start mark, right
// and left speeds, blade command, spare word and xor checksum.
// an item goes through an input register, one pass of mixing and scaling
// logic, and the frame register, which the item enters from the input
// register once the frame register is free. one item is taken every
// cycle, also while a finished frame waits in the frame register, as long
// as the frame register frees up in the same cycle.
// samples whose speeds are both zero make a frame only for the first three
// in a row; unused func codes make no frame and change nothing.
// when out_ready is low the frame holds, the input register fills and then
// in_ready drops until the frame is taken.
// reset empties both registers, clears stored speeds, blade code and zero run
// count, and loads the default centers, band and dead zone.
// the apb port (pready always high) reads and writes the four settings.
module joystick_drive_frame_builder_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic        [3:0]                    paddr,
    input  logic        [31:0]                   pwdata,
    output logic        [31:0]                   prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic        [1:0]                    func,
    input  logic        [jdfb_pkg::RAW_W-1:0]    x_sample,
    input  logic        [jdfb_pkg::RAW_W-1:0]    y_sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic        [jdfb_pkg::WORD_W-1:0]   start_word,
    output logic signed [jdfb_pkg::OUT_W-1:0]    right_word,
    output logic signed [jdfb_pkg::OUT_W-1:0]    left_word,
    output logic        [jdfb_pkg::WORD_W-1:0]   command_word,
    output logic                                 spare_word,
    output logic        [jdfb_pkg::WORD_W-1:0]   check_word
);

    logic [jdfb_pkg::RAW_W-1:0]  x_center_reg;
    logic [jdfb_pkg::RAW_W-1:0]  y_center_reg;
    logic [jdfb_pkg::BAND_W-1:0] center_band_reg;
    logic [jdfb_pkg::BAND_W-1:0] dead_zone_reg;
    logic                        cfg_write;

    logic                        in_vld_reg;
    jdfb_pkg::func_t             func_reg;
    logic [jdfb_pkg::RAW_W-1:0]  xs_reg;
    logic [jdfb_pkg::RAW_W-1:0]  ys_reg;

    logic signed [jdfb_pkg::SPD_W-1:0] last_left_reg;
    logic signed [jdfb_pkg::SPD_W-1:0] last_right_reg;
    logic signed [jdfb_pkg::SPD_W-1:0] last_left_next;
    logic signed [jdfb_pkg::SPD_W-1:0] last_right_next;
    logic [jdfb_pkg::ZC_W-1:0]         zcnt_reg;
    logic [jdfb_pkg::ZC_W-1:0]         zcnt_next;
    logic [1:0]                        blade_reg;
    logic [1:0]                        blade_next;

    logic                              out_vld_reg;
    logic                              out_vld_next;
    logic signed [jdfb_pkg::OUT_W-1:0] right_reg;
    logic signed [jdfb_pkg::OUT_W-1:0] left_reg;
    logic [jdfb_pkg::WORD_W-1:0]       cmd_reg;
    logic [jdfb_pkg::WORD_W-1:0]       check_reg;

    logic                              fire;
    logic                              emit;
    logic signed [jdfb_pkg::DIFF_W-1:0] dx;
    logic signed [jdfb_pkg::DIFF_W-1:0] dy;
    logic signed [jdfb_pkg::DIFF_W-1:0] dy_z;
    logic signed [jdfb_pkg::DIFF_W-1:0] band_s;
    logic signed [jdfb_pkg::MIX_W-1:0]  mix_l;
    logic signed [jdfb_pkg::MIX_W-1:0]  mix_r;
    logic signed [jdfb_pkg::SPD_W-1:0]  spd_l;
    logic signed [jdfb_pkg::SPD_W-1:0]  spd_r;
    logic signed [jdfb_pkg::SPD_W-1:0]  frame_r;
    logic signed [jdfb_pkg::SPD_W-1:0]  frame_l;
    logic [jdfb_pkg::WORD_W-1:0]        frame_cmd;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_center_reg    <= jdfb_pkg::X_CENTER_RST;
            y_center_reg    <= jdfb_pkg::Y_CENTER_RST;
            center_band_reg <= jdfb_pkg::CENTER_BAND_RST;
            dead_zone_reg   <= jdfb_pkg::DEAD_ZONE_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                jdfb_pkg::REG_X_CENTER:    x_center_reg    <= pwdata[jdfb_pkg::RAW_W-1:0];
                jdfb_pkg::REG_Y_CENTER:    y_center_reg    <= pwdata[jdfb_pkg::RAW_W-1:0];
                jdfb_pkg::REG_CENTER_BAND: center_band_reg <= pwdata[jdfb_pkg::BAND_W-1:0];
                jdfb_pkg::REG_DEAD_ZONE:   dead_zone_reg   <= pwdata[jdfb_pkg::BAND_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            jdfb_pkg::REG_X_CENTER:    prdata = 32'(x_center_reg);
            jdfb_pkg::REG_Y_CENTER:    prdata = 32'(y_center_reg);
            jdfb_pkg::REG_CENTER_BAND: prdata = 32'(center_band_reg);
            jdfb_pkg::REG_DEAD_ZONE:   prdata = 32'(dead_zone_reg);
            default:                   prdata = '0;
        endcase
    end

    // input register
    assign fire     = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            func_reg <= jdfb_pkg::func_t'(func);
            xs_reg   <= x_sample;
            ys_reg   <= y_sample;
        end
    end

    // centering and mixing
    always_comb
    begin
        dx     = $signed({1'b0, xs_reg}) - $signed({1'b0, x_center_reg});
        dy     = $signed({1'b0, ys_reg}) - $signed({1'b0, y_center_reg});
        band_s = $signed({2'b00, center_band_reg});
        dy_z   = ((dy < band_s) && (dy > -band_s)) ? '0 : dy;
        if ((dx < -band_s) || (dx > band_s))
        begin
            if (dy_z >= 0)
            begin
                mix_l = jdfb_pkg::MIX_W'(dy_z) + jdfb_pkg::MIX_W'(dx);
                mix_r = jdfb_pkg::MIX_W'(dy_z) - jdfb_pkg::MIX_W'(dx);
            end
            else
            begin
                mix_l = jdfb_pkg::MIX_W'(dy_z) - jdfb_pkg::MIX_W'(dx);
                mix_r = jdfb_pkg::MIX_W'(dy_z) + jdfb_pkg::MIX_W'(dx);
            end
        end
        else
        begin
            mix_l = jdfb_pkg::MIX_W'(dy_z);
            mix_r = jdfb_pkg::MIX_W'(dy_z);
        end
    end

    jdfb_shape u_shape_left (
        .mix       (mix_l),
        .dead_zone (dead_zone_reg),
        .speed     (spd_l)
    );

    jdfb_shape u_shape_right (
        .mix       (mix_r),
        .dead_zone (dead_zone_reg),
        .speed     (spd_r)
    );

    // state update and frame contents
    always_comb
    begin
        last_left_next  = last_left_reg;
        last_right_next = last_right_reg;
        zcnt_next       = zcnt_reg;
        blade_next      = blade_reg;
        emit            = 1'b0;
        frame_r         = last_right_reg;
        frame_l         = last_left_reg;
        case (func_reg)
            jdfb_pkg::FUNC_SAMPLE:
            begin
                last_left_next  = spd_l;
                last_right_next = spd_r;
                frame_r         = -spd_r;
                frame_l         = -spd_l;
                if ((spd_l != '0) || (spd_r != '0))
                begin
                    zcnt_next = '0;
                    emit      = 1'b1;
                end
                else if (zcnt_reg < jdfb_pkg::ZC_W'(jdfb_pkg::ZERO_REPEATS))
                begin
                    zcnt_next = zcnt_reg + 1'b1;
                    emit      = 1'b1;
                end
            end
            jdfb_pkg::FUNC_BLADE_RUN, jdfb_pkg::FUNC_BLADE_STOP:
            begin
                blade_next = func_reg;
                emit       = 1'b1;
            end
            default:
            begin
            end
        endcase
        frame_cmd = jdfb_pkg::cmd_of(blade_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_left_reg  <= '0;
            last_right_reg <= '0;
            zcnt_reg       <= '0;
            blade_reg      <= jdfb_pkg::BLADE_NONE;
        end
        else if (fire)
        begin
            last_left_reg  <= last_left_next;
            last_right_reg <= last_right_next;
            zcnt_reg       <= zcnt_next;
            blade_reg      <= blade_next;
        end
    end

    // frame register
    always_comb
    begin
        if (fire)
        begin
            out_vld_next = emit;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            right_reg <= jdfb_pkg::OUT_W'(frame_r);
            left_reg  <= jdfb_pkg::OUT_W'(frame_l);
            cmd_reg   <= frame_cmd;
            check_reg <= jdfb_pkg::START_MARK
                       ^ jdfb_pkg::WORD_W'(frame_r)
                       ^ jdfb_pkg::WORD_W'(frame_l)
                       ^ frame_cmd;
        end
    end

    assign out_valid    = out_vld_reg;
    assign start_word   = jdfb_pkg::START_MARK;
    assign right_word   = right_reg;
    assign left_word    = left_reg;
    assign command_word = cmd_reg;
    assign spare_word   = 1'b0;
    assign check_word   = check_reg;

    // zero run count saturates at the repeat limit
    a_zcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        zcnt_reg <= jdfb_pkg::ZC_W'(jdfb_pkg::ZERO_REPEATS))
        else $error("zero run count above limit");

    // a blade run press always yields a frame carrying the on command
    a_blade_run_frame: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (func_reg == jdfb_pkg::FUNC_BLADE_RUN)
        |=> out_valid && (command_word == jdfb_pkg::CMD_ON))
        else $error("blade run press without on frame");

    // an unused func code leaves the stored state alone
    a_unused_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (func_reg == jdfb_pkg::FUNC_UNUSED)
        |=> $stable(blade_reg) && $stable(zcnt_reg) && $stable(last_left_reg)
            && $stable(last_right_reg) && !out_valid)
        else $error("unused func code changed state or made a frame");

    // a suppressed all-zero sample makes no frame
    a_zero_suppress: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (func_reg == jdfb_pkg::FUNC_SAMPLE) && (spd_l == '0) && (spd_r == '0)
        && (zcnt_reg == jdfb_pkg::ZC_W'(jdfb_pkg::ZERO_REPEATS))
        |=> !out_valid)
        else $error("zero frame past repeat limit");

endmodule
